### rtl/vcf_pkg.sv
// ---------------------------------------------------------------------------
// vcf_pkg
// Shared types, constants and fixed-point helpers of the velocity fusion core.
// ---------------------------------------------------------------------------
package vcf_pkg;

	// Register indexes of the configuration port.
	localparam logic REG_SONAR_WEIGHT    = 1'b0;
	localparam logic REG_ACCEL_SMOOTHING = 1'b1;

	// Input opcodes.
	localparam logic OP_FUSE   = 1'b0;
	localparam logic OP_WARMUP = 1'b1;

	// Fixed-point constants.
	localparam int unsigned Q16_ONE        = 65536;
	localparam int          G_SCALED       = 1048576;
	localparam int          STILL_ACC_MAX  = 20971;
	localparam int unsigned STILL_NEEDED   = 3;
	localparam int unsigned STILL_CAP      = 255;
	localparam int unsigned GRAVITY_CMS    = 981;
	localparam int unsigned INTEG_DIVISOR  = 512000;
	localparam int unsigned BLEND_KEEP     = 19;
	localparam int unsigned WEIGHT_RESET   = 32768;
	localparam int unsigned SMOOTH_RESET   = 6554;

	// Datapath widths.
	localparam int MUL_A_W = 38;
	localparam int MUL_B_W = 18;
	localparam int WIDE_W  = 56;
	localparam int DEN_W   = 21;
	localparam int DVD_W   = 53;
	localparam int RAD_W   = 44;
	localparam int ROOT_W  = 22;
	localparam int ACC_W   = 24;

	typedef logic signed [WIDE_W-1:0] wide_t;

	// Request to the shared divider.
	typedef struct packed {
		logic              start;
		wide_t             num;
		logic [DEN_W-1:0]  den;
	} div_req_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE, ST_SQX, ST_SQY, ST_SQZ, ST_SQE, ST_SQW,
		ST_LP1, ST_LP2, ST_LP3, ST_LPR,
		ST_IN1, ST_IN2, ST_IN3, ST_INW,
		ST_BL1, ST_BL2, ST_BL3, ST_BLW,
		ST_VS, ST_VSW, ST_SV, ST_SVW,
		ST_FU1, ST_FU2, ST_FU3, ST_OUT
	} state_t;

	// Arithmetic shift right by n with rounding to nearest, ties away from zero.
	function automatic wide_t rnd_shr(input wide_t x, input int unsigned n);
		logic [WIDE_W-1:0] mag;
		logic [WIDE_W-1:0] q;
		mag = x[WIDE_W-1] ? $unsigned(-x) : $unsigned(x);
		q   = (mag + (WIDE_W'(1) << (n - 1))) >> n;
		return x[WIDE_W-1] ? -$signed(q) : $signed(q);
	endfunction

	// Saturate to a signed 32-bit value.
	function automatic logic signed [31:0] sat32(input wide_t x);
		if (x > wide_t'(32'sh7FFF_FFFF)) begin
			return 32'sh7FFF_FFFF;
		end else if (x < -wide_t'(64'sh8000_0000)) begin
			return 32'sh8000_0000;
		end
		return x[31:0];
	endfunction

	// Saturate to a signed 24-bit value.
	function automatic logic signed [23:0] sat24(input wide_t x);
		if (x > wide_t'(24'sh7F_FFFF)) begin
			return 24'sh7F_FFFF;
		end else if (x < -wide_t'(32'sh0080_0000)) begin
			return 24'sh80_0000;
		end
		return x[23:0];
	endfunction

endpackage

### rtl/vcf_mul.sv
// ---------------------------------------------------------------------------
// vcf_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module vcf_mul (
	input  logic                                clk,
	input  logic signed [vcf_pkg::MUL_A_W-1:0]  a,
	input  logic signed [vcf_pkg::MUL_B_W-1:0]  b,
	output vcf_pkg::wide_t                      p_s1
);

	// One product per cycle, available on the next cycle.
	always_ff @(posedge clk) begin
		p_s1 <= vcf_pkg::wide_t'(a) * vcf_pkg::wide_t'(b);
	end

endmodule

### rtl/vcf_div.sv
// ---------------------------------------------------------------------------
// vcf_div
// Shared restoring divider, one quotient bit per cycle, rounding to nearest
// with ties away from zero.
// ---------------------------------------------------------------------------
module vcf_div (
	input  logic                clk,
	input  logic                arst_n,
	input  vcf_pkg::div_req_t   req,
	output logic                done,
	output vcf_pkg::wide_t      quot
);

	localparam int CNT_W = $clog2(vcf_pkg::DVD_W + 1);

	logic [vcf_pkg::DVD_W-1:0]   dvd_q;
	logic [vcf_pkg::DEN_W-1:0]   rem_q;
	logic [vcf_pkg::DEN_W-1:0]   den_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        neg_q;
	logic                        busy_q;
	logic                        done_q;
	logic [vcf_pkg::WIDE_W-1:0]  num_mag;
	logic [vcf_pkg::DEN_W:0]     rem_sh;
	logic                        fit;

	// Magnitude of the request, biased by half the divisor for rounding.
	assign num_mag = req.num[vcf_pkg::WIDE_W-1] ? $unsigned(-req.num) : $unsigned(req.num);
	assign rem_sh  = {rem_q, dvd_q[vcf_pkg::DVD_W-1]};
	assign fit     = rem_sh >= {1'b0, den_q};

	// Control: counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(vcf_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift the dividend through the partial remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= num_mag[vcf_pkg::DVD_W-1:0] + vcf_pkg::DVD_W'(req.den >> 1);
			rem_q <= '0;
			den_q <= req.den;
			neg_q <= req.num[vcf_pkg::WIDE_W-1];
		end else if (busy_q) begin
			rem_q <= fit ? vcf_pkg::DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[vcf_pkg::DEN_W-1:0];
			dvd_q <= {dvd_q[vcf_pkg::DVD_W-2:0], fit};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed(vcf_pkg::WIDE_W'(dvd_q)) : $signed(vcf_pkg::WIDE_W'(dvd_q));

endmodule

### rtl/vcf_sqrt.sv
// ---------------------------------------------------------------------------
// vcf_sqrt
// Integer square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module vcf_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [vcf_pkg::RAD_W-1:0]    radicand,
	output logic                         done,
	output logic [vcf_pkg::ROOT_W-1:0]   root
);

	localparam int REM_W = vcf_pkg::ROOT_W + 2;
	localparam int CNT_W = $clog2(vcf_pkg::ROOT_W + 1);

	logic [vcf_pkg::RAD_W-1:0]   rad_q;
	logic [REM_W-1:0]            rem_q;
	logic [vcf_pkg::ROOT_W-1:0]  root_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [REM_W+1:0]            rem_sh;
	logic [REM_W+1:0]            trial;
	logic                        fit;

	// Bring down two radicand bits and try a one in the next root position.
	assign rem_sh = {rem_q, rad_q[vcf_pkg::RAD_W-1 -: 2]};
	assign trial  = (REM_W+2)'({root_q, 2'b01});
	assign fit    = rem_sh >= trial;

	// Control: counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(vcf_pkg::ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[vcf_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= fit ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
			root_q <= {root_q[vcf_pkg::ROOT_W-2:0], fit};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### rtl/velocity_complementary_fusion_core.sv
// ---------------------------------------------------------------------------
// velocity_complementary_fusion_core
// Sonar and accelerometer velocity fusion on one shared multiplier, divider
// and square-root unit.
// ---------------------------------------------------------------------------
// A fuse request runs the 22-step square root, then four passes through the
// 53-step divider (inertial integration, velocity blend, and the two sonar
// velocities), with sequencer and multiplier steps in between. A warm-up
// request skips the arithmetic and goes straight to the output state. The
// block holds in_stall high while a request is in work and drops it as the
// result moves into the output register; a previous result held there by
// out_stall delays that move for as long as the stall lasts. Configuration
// is written through cfg_we, cfg_index and cfg_data; the user must do so
// only while the block is idle, which the block itself does not enforce.
module velocity_complementary_fusion_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic [14:0]         distance,
	input  logic signed [15:0]  accel_x,
	input  logic signed [15:0]  accel_y,
	input  logic signed [15:0]  accel_z,
	input  logic [15:0]         elapsed_ms,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [23:0]  sonar_velocity,
	output logic signed [23:0]  inertial_velocity,
	output logic signed [23:0]  fused_velocity,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [16:0]         cfg_data
);

	vcf_pkg::state_t state_q, state_nxt;

	// Configuration.
	logic [16:0] weight_q, smooth_cfg_q;
	logic [16:0] k, w;

	// Latched request.
	logic [14:0]        dist_q;
	logic signed [15:0] ax_q, ay_q, az_q;
	logic [15:0]        ms_q;

	// Persistent state.
	logic [14:0]                       last_q;
	logic signed [31:0]                acc_q;
	logic signed [vcf_pkg::ACC_W-1:0]  smooth_q, prev_q;
	logic [7:0]                        still_q;

	// Scratch registers.
	logic [31:0]                       sum_q;
	logic signed [vcf_pkg::ACC_W-1:0]  amag_q;
	logic signed [15:0]                diff_q;
	vcf_pkg::wide_t                    t_q, vs_q, sv_q;
	logic                              out_valid_q;
	logic signed [23:0]                sonar_q, inert_q, fused_q;

	// Shared units.
	logic signed [vcf_pkg::MUL_A_W-1:0] mul_a;
	logic signed [vcf_pkg::MUL_B_W-1:0] mul_b;
	vcf_pkg::wide_t                     mul_p_s1;
	vcf_pkg::div_req_t                  div_req;
	logic                               div_done;
	vcf_pkg::wide_t                     div_quot;
	logic                               sqrt_start;
	logic                               sqrt_done;
	logic [vcf_pkg::ROOT_W-1:0]         sqrt_root;

	// Derived values.
	logic                   in_take, out_take, out_load;
	logic [31:0]            sq_sum;
	logic [vcf_pkg::DEN_W-1:0] ms20;
	vcf_pkg::wide_t         diff_w, diffs, diffk, alp_w, acc_sum, v_blend;
	logic                   valid_tick, still;
	logic [14:0]            abs_diff;
	logic [25:0]            abs_diff_k;
	logic [7:0]             still_nxt;

	vcf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_s1(mul_p_s1));
	vcf_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .done(div_done), .quot(div_quot));
	vcf_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.radicand({sum_q + mul_p_s1[31:0], 12'b0}), .done(sqrt_done), .root(sqrt_root)
	);

	// Handshakes.
	assign in_stall = (state_q != vcf_pkg::ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign out_load = (state_q == vcf_pkg::ST_OUT) && (!out_valid_q || !out_stall);

	// Coefficients above one act as one.
	assign k = (smooth_cfg_q > 17'(vcf_pkg::Q16_ONE)) ? 17'(vcf_pkg::Q16_ONE) : smooth_cfg_q;
	assign w = (weight_q > 17'(vcf_pkg::Q16_ONE)) ? 17'(vcf_pkg::Q16_ONE) : weight_q;

	// Constant scalings as shift-and-add.
	assign sq_sum     = sum_q + mul_p_s1[31:0];
	assign ms20       = vcf_pkg::DEN_W'({ms_q, 4'b0}) + vcf_pkg::DEN_W'({ms_q, 2'b0});
	assign diff_w     = vcf_pkg::wide_t'(diff_q);
	assign diffs      = (diff_w <<< 18) - (diff_w <<< 12) - (diff_w <<< 11);
	assign diffk      = (diff_w <<< 10) - (diff_w <<< 4) - (diff_w <<< 3);
	assign alp_w      = vcf_pkg::rnd_shr(t_q, 16);
	assign acc_sum    = vcf_pkg::wide_t'(acc_q) + div_quot;
	assign abs_diff   = diff_q[15] ? 15'(-diff_q) : diff_q[14:0];
	assign abs_diff_k = (26'(abs_diff) << 10) - (26'(abs_diff) << 4) - (26'(abs_diff) << 3);

	// Stillness test and run counter.
	assign valid_tick = (dist_q != '0);
	assign still = valid_tick
		&& (smooth_q <= vcf_pkg::ACC_W'(vcf_pkg::STILL_ACC_MAX))
		&& (smooth_q >= -vcf_pkg::ACC_W'(vcf_pkg::STILL_ACC_MAX))
		&& (abs_diff_k < 26'({ms_q, 3'b0}));
	assign still_nxt = (still_q < 8'(vcf_pkg::STILL_CAP)) ? still_q + 1'b1 : still_q;
	assign v_blend = (still && (still_nxt >= 8'(vcf_pkg::STILL_NEEDED)))
		? '0 : vcf_pkg::wide_t'(vcf_pkg::sat32(div_quot));

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vcf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Sequencer: next state and shared-unit operands.
	always_comb begin
		state_nxt     = state_q;
		mul_a         = '0;
		mul_b         = '0;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = vcf_pkg::DEN_W'(1);
		sqrt_start    = 1'b0;
		case (state_q)
			vcf_pkg::ST_IDLE: begin
				if (in_take) begin
					state_nxt = (opcode == vcf_pkg::OP_WARMUP) ? vcf_pkg::ST_OUT : vcf_pkg::ST_SQX;
				end
			end
			vcf_pkg::ST_SQX: begin
				mul_a = vcf_pkg::MUL_A_W'(ax_q);
				mul_b = vcf_pkg::MUL_B_W'(ax_q);
				state_nxt = vcf_pkg::ST_SQY;
			end
			vcf_pkg::ST_SQY: begin
				mul_a = vcf_pkg::MUL_A_W'(ay_q);
				mul_b = vcf_pkg::MUL_B_W'(ay_q);
				state_nxt = vcf_pkg::ST_SQZ;
			end
			vcf_pkg::ST_SQZ: begin
				mul_a = vcf_pkg::MUL_A_W'(az_q);
				mul_b = vcf_pkg::MUL_B_W'(az_q);
				state_nxt = vcf_pkg::ST_SQE;
			end
			vcf_pkg::ST_SQE: begin
				sqrt_start = 1'b1;
				state_nxt  = vcf_pkg::ST_SQW;
			end
			vcf_pkg::ST_SQW: begin
				if (sqrt_done) begin
					state_nxt = vcf_pkg::ST_LP1;
				end
			end
			vcf_pkg::ST_LP1: begin
				mul_a = vcf_pkg::MUL_A_W'(amag_q);
				mul_b = $signed({1'b0, k});
				state_nxt = vcf_pkg::ST_LP2;
			end
			vcf_pkg::ST_LP2: begin
				mul_a = vcf_pkg::MUL_A_W'(smooth_q);
				mul_b = $signed({1'b0, 17'(17'(vcf_pkg::Q16_ONE) - k)});
				state_nxt = vcf_pkg::ST_LP3;
			end
			vcf_pkg::ST_LP3: begin
				state_nxt = vcf_pkg::ST_LPR;
			end
			vcf_pkg::ST_LPR: begin
				state_nxt = vcf_pkg::ST_IN1;
			end
			vcf_pkg::ST_IN1: begin
				mul_a = vcf_pkg::MUL_A_W'(smooth_q) + vcf_pkg::MUL_A_W'(prev_q);
				mul_b = vcf_pkg::MUL_B_W'(vcf_pkg::GRAVITY_CMS);
				state_nxt = vcf_pkg::ST_IN2;
			end
			vcf_pkg::ST_IN2: begin
				mul_a = $signed(mul_p_s1[vcf_pkg::MUL_A_W-1:0]);
				mul_b = $signed({2'b00, ms_q});
				state_nxt = vcf_pkg::ST_IN3;
			end
			vcf_pkg::ST_IN3: begin
				div_req.start = 1'b1;
				div_req.num   = mul_p_s1;
				div_req.den   = vcf_pkg::DEN_W'(vcf_pkg::INTEG_DIVISOR);
				state_nxt     = vcf_pkg::ST_INW;
			end
			vcf_pkg::ST_INW: begin
				if (div_done) begin
					state_nxt = vcf_pkg::ST_BL1;
				end
			end
			vcf_pkg::ST_BL1: begin
				mul_a = vcf_pkg::MUL_A_W'(acc_q);
				mul_b = vcf_pkg::MUL_B_W'(vcf_pkg::BLEND_KEEP);
				state_nxt = vcf_pkg::ST_BL2;
			end
			vcf_pkg::ST_BL2: begin
				mul_a = $signed(mul_p_s1[vcf_pkg::MUL_A_W-1:0]);
				mul_b = $signed({2'b00, ms_q});
				state_nxt = vcf_pkg::ST_BL3;
			end
			vcf_pkg::ST_BL3: begin
				div_req.start = 1'b1;
				div_req.num   = mul_p_s1 + diffs;
				div_req.den   = ms20;
				state_nxt     = vcf_pkg::ST_BLW;
			end
			vcf_pkg::ST_BLW: begin
				if (div_done) begin
					state_nxt = vcf_pkg::ST_VS;
				end
			end
			vcf_pkg::ST_VS: begin
				div_req.start = 1'b1;
				div_req.num   = diffs;
				div_req.den   = vcf_pkg::DEN_W'(ms_q);
				state_nxt     = vcf_pkg::ST_VSW;
			end
			vcf_pkg::ST_VSW: begin
				if (div_done) begin
					state_nxt = vcf_pkg::ST_SV;
				end
			end
			vcf_pkg::ST_SV: begin
				div_req.start = 1'b1;
				div_req.num   = diffk;
				div_req.den   = vcf_pkg::DEN_W'(ms_q);
				state_nxt     = vcf_pkg::ST_SVW;
			end
			vcf_pkg::ST_SVW: begin
				if (div_done) begin
					state_nxt = vcf_pkg::ST_FU1;
				end
			end
			vcf_pkg::ST_FU1: begin
				mul_a = $signed(vs_q[vcf_pkg::MUL_A_W-1:0]);
				mul_b = $signed({1'b0, w});
				state_nxt = vcf_pkg::ST_FU2;
			end
			vcf_pkg::ST_FU2: begin
				mul_a = vcf_pkg::MUL_A_W'(acc_q);
				mul_b = $signed({1'b0, 17'(17'(vcf_pkg::Q16_ONE) - w)});
				state_nxt = vcf_pkg::ST_FU3;
			end
			vcf_pkg::ST_FU3: begin
				state_nxt = vcf_pkg::ST_OUT;
			end
			vcf_pkg::ST_OUT: begin
				if (out_load) begin
					state_nxt = vcf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = vcf_pkg::ST_IDLE;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q     <= 17'(vcf_pkg::WEIGHT_RESET);
			smooth_cfg_q <= 17'(vcf_pkg::SMOOTH_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				vcf_pkg::REG_SONAR_WEIGHT:    weight_q     <= cfg_data;
				vcf_pkg::REG_ACCEL_SMOOTHING: smooth_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Filter state, cleared by reset and by a warm-up request, which also loads the last distance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			acc_q    <= '0;
			smooth_q <= '0;
			prev_q   <= '0;
			still_q  <= '0;
		end else begin
			if (in_take && (opcode == vcf_pkg::OP_WARMUP)) begin
				last_q   <= distance;
				acc_q    <= '0;
				smooth_q <= '0;
				prev_q   <= '0;
				still_q  <= '0;
			end
			if (state_q == vcf_pkg::ST_LPR) begin
				smooth_q <= alp_w[vcf_pkg::ACC_W-1:0];
				if (valid_tick) begin
					last_q <= dist_q;
				end
			end
			if ((state_q == vcf_pkg::ST_INW) && div_done) begin
				acc_q  <= vcf_pkg::sat32(acc_sum);
				prev_q <= smooth_q;
			end
			if ((state_q == vcf_pkg::ST_BLW) && div_done) begin
				acc_q <= v_blend[31:0];
				if (still) begin
					still_q <= still_nxt;
				end else if (valid_tick) begin
					still_q <= '0;
				end
			end
		end
	end

	// Request latch and scratch registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			dist_q <= distance;
			ax_q   <= accel_x;
			ay_q   <= accel_y;
			az_q   <= accel_z;
			ms_q   <= (elapsed_ms == '0) ? 16'd1 : elapsed_ms;
			t_q    <= '0;
			sv_q   <= '0;
		end
		case (state_q)
			vcf_pkg::ST_SQY: sum_q <= mul_p_s1[31:0];
			vcf_pkg::ST_SQZ: sum_q <= sq_sum;
			vcf_pkg::ST_SQW: begin
				if (sqrt_done) begin
					amag_q <= vcf_pkg::ACC_W'(sqrt_root) - vcf_pkg::ACC_W'(vcf_pkg::G_SCALED);
				end
			end
			vcf_pkg::ST_LP2: t_q <= mul_p_s1;
			vcf_pkg::ST_LP3: t_q <= t_q + mul_p_s1;
			vcf_pkg::ST_LPR: diff_q <= valid_tick ? $signed({1'b0, dist_q}) - $signed({1'b0, last_q}) : '0;
			vcf_pkg::ST_VSW: begin
				if (div_done) begin
					vs_q <= div_quot;
				end
			end
			vcf_pkg::ST_SVW: begin
				if (div_done) begin
					sv_q <= div_quot;
				end
			end
			vcf_pkg::ST_FU2: t_q <= mul_p_s1;
			vcf_pkg::ST_FU3: t_q <= t_q + mul_p_s1;
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sonar_q <= vcf_pkg::sat24(sv_q);
			inert_q <= vcf_pkg::sat24(vcf_pkg::rnd_shr(vcf_pkg::wide_t'(acc_q), 8));
			fused_q <= vcf_pkg::sat24(vcf_pkg::rnd_shr(t_q, 24));
		end
	end

	assign out_valid         = out_valid_q;
	assign sonar_velocity    = sonar_q;
	assign inertial_velocity = inert_q;
	assign fused_velocity    = fused_q;

endmodule

### rtl/vcf_checker.sv
// ---------------------------------------------------------------------------
// vcf_checker
// Port-level checks of the velocity fusion core, bound to the top level.
// ---------------------------------------------------------------------------
module vcf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic signed [23:0]  sonar_velocity,
	input logic signed [23:0]  inertial_velocity,
	input logic signed [23:0]  fused_velocity
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sonar_velocity)
			&& $stable(inertial_velocity) && $stable(fused_velocity))
		else $error("stalled result changed");

	// An accepted request makes the block busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after request");

	// A result never shows up on the cycle right after a request is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind velocity_complementary_fusion_core vcf_checker u_vcf_checker (.*);

### sim/tb_velocity_complementary_fusion_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_velocity_complementary_fusion_core
// Self-checking bench for the velocity fusion core. A fixed-point predictor
// tracks the filter state and configuration, computes the expected velocities
// of every accepted request, and a scoreboard compares each delivered result
// with the oldest expectation. Stimulus is a short directed set followed by
// random sensor sequences under several weight settings, with bursty requests
// and random output stalls.
// ---------------------------------------------------------------------------
module tb_velocity_complementary_fusion_core;

	localparam longint ONE_Q16   = 65536;
	localparam longint G_Q20     = 1048576;
	localparam longint STILL_MAX = 20971;
	localparam longint OUT_HI    = 8388607;
	localparam longint OUT_LO    = -8388608;
	localparam longint I32_HI    = 2147483647;
	localparam longint I32_LO    = -64'sd2147483648;

	typedef struct {
		logic               op;
		logic [14:0]        sonar_dist;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic [15:0]        ms;
	} fuse_req_t;

	typedef struct {
		logic signed [23:0] sonar;
		logic signed [23:0] inertial;
		logic signed [23:0] fused;
	} velocity_t;

	// Velocity predictor and store of expected results.
	class velocity_scoreboard;
		longint    weight_reg;
		longint    smooth_reg;
		longint    last_dist;
		longint    vel_acc;
		longint    acc_lp;
		longint    acc_lp_prev;
		longint    still_run;
		velocity_t pending[$];
		int        errors;

		function void clear();
			weight_reg = vcf_pkg::WEIGHT_RESET;
			smooth_reg = vcf_pkg::SMOOTH_RESET;
			last_dist = 0;
			vel_acc = 0;
			acc_lp = 0;
			acc_lp_prev = 0;
			still_run = 0;
			errors = 0;
			pending.delete();
		endfunction

		function void set_register(logic idx, logic [16:0] val);
			if (idx == vcf_pkg::REG_SONAR_WEIGHT) begin
				weight_reg = val;
			end else begin
				smooth_reg = val;
			end
		endfunction

		// Division rounded to nearest, ties away from zero.
		function longint round_div(longint n, longint d);
			longint mag;
			longint q;
			mag = (n < 0) ? -n : n;
			q = (mag + d / 2) / d;
			return (n < 0) ? -q : q;
		endfunction

		function longint int_sqrt(longint unsigned x);
			longint unsigned res;
			longint unsigned b;
			res = 0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= res + b) begin
					x = x - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return longint'(res);
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		// Advance the filter state by one accepted request and queue its result.
		function void note_request(fuse_req_t r);
			velocity_t e;
			longint ms, k, w, ax, ay, az, amag, alp, diff, v, vs, ad;
			longint unsigned sq;
			bit valid, still;
			if (r.op == vcf_pkg::OP_WARMUP) begin
				last_dist = r.sonar_dist;
				vel_acc = 0;
				acc_lp = 0;
				acc_lp_prev = 0;
				still_run = 0;
				e.sonar = 0;
				e.inertial = 0;
				e.fused = 0;
				pending.push_back(e);
				return;
			end
			ms = (r.ms == 0) ? 1 : r.ms;
			k = (smooth_reg > ONE_Q16) ? ONE_Q16 : smooth_reg;
			w = (weight_reg > ONE_Q16) ? ONE_Q16 : weight_reg;
			ax = r.ax;
			ay = r.ay;
			az = r.az;
			sq = ax * ax + ay * ay + az * az;
			amag = int_sqrt(sq << 12) - G_Q20;
			alp = round_div(k * amag + (ONE_Q16 - k) * acc_lp, ONE_Q16);
			acc_lp = alp;
			valid = (r.sonar_dist != 0);
			diff = valid ? (longint'(r.sonar_dist) - last_dist) : 0;
			if (valid) last_dist = r.sonar_dist;
			v = vel_acc + round_div((alp + acc_lp_prev) * ms * 981, 512000);
			v = clip(v, I32_LO, I32_HI);
			acc_lp_prev = alp;
			v = round_div(19 * v * ms + diff * 256000, 20 * ms);
			v = clip(v, I32_LO, I32_HI);
			ad = (diff < 0) ? -diff : diff;
			still = valid && alp <= STILL_MAX && alp >= -STILL_MAX && ad * 1000 < 8 * ms;
			if (still) begin
				if (still_run < vcf_pkg::STILL_CAP) still_run++;
				if (still_run >= vcf_pkg::STILL_NEEDED) v = 0;
			end else if (valid) begin
				still_run = 0;
			end
			vel_acc = v;
			vs = round_div(diff * 256000, ms);
			e.sonar = 24'(clip(round_div(diff * 1000, ms), OUT_LO, OUT_HI));
			e.inertial = 24'(clip(round_div(v, 256), OUT_LO, OUT_HI));
			e.fused = 24'(clip(round_div(w * vs + (ONE_Q16 - w) * v, 64'd1 << 24),
				OUT_LO, OUT_HI));
			pending.push_back(e);
		endfunction

		// Compare one delivered result with the oldest expectation.
		function void check_result(velocity_t got);
			velocity_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %0d %0d %0d",
					got.sonar, got.inertial, got.fused);
				return;
			end
			e = pending.pop_front();
			if (got.sonar !== e.sonar || got.inertial !== e.inertial || got.fused !== e.fused) begin
				errors++;
				if (errors <= 10) $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
					e.sonar, e.inertial, e.fused, got.sonar, got.inertial, got.fused);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               opcode = vcf_pkg::OP_FUSE;
	logic [14:0]        distance = '0;
	logic signed [15:0] accel_x = '0;
	logic signed [15:0] accel_y = '0;
	logic signed [15:0] accel_z = '0;
	logic [15:0]        elapsed_ms = 16'd1;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [23:0] sonar_velocity;
	logic signed [23:0] inertial_velocity;
	logic signed [23:0] fused_velocity;
	logic               cfg_we = 1'b0;
	logic               cfg_index = vcf_pkg::REG_SONAR_WEIGHT;
	logic [16:0]        cfg_data = '0;

	velocity_scoreboard sb = new();
	int                 burst_left = 0;
	int                 stall_left = 0;
	int                 cur_dist = 2000;

	velocity_complementary_fusion_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .distance(distance),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.elapsed_ms(elapsed_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.sonar_velocity(sonar_velocity), .inertial_velocity(inertial_velocity),
		.fused_velocity(fused_velocity),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Output stall pattern: runs of free flow and stall of random length.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(1, 60);
			end else begin
				out_stall <= 1'b0;
				stall_left <= $urandom_range(1, 400);
			end
		end else begin
			stall_left <= stall_left - 1;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		velocity_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.sonar = sonar_velocity;
			got.inertial = inertial_velocity;
			got.fused = fused_velocity;
			sb.check_result(got);
		end
	end

	// Present one request, holding it until accepted; gaps fall between bursts.
	task automatic send_request(fuse_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 30);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= r.op;
		distance <= r.sonar_dist;
		accel_x <= r.ax;
		accel_y <= r.ay;
		accel_z <= r.az;
		elapsed_ms <= r.ms;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sb.note_request(r);
	endtask

	task automatic send_fields(logic op, int d, int x, int y, int z, int ms);
		fuse_req_t r;
		r.op = op;
		r.sonar_dist = 15'(d);
		r.ax = 16'(x);
		r.ay = 16'(y);
		r.az = 16'(z);
		r.ms = 16'(ms);
		send_request(r);
	endtask

	// Let all outstanding results drain, then write both registers.
	task automatic write_config(int w, int k);
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= vcf_pkg::REG_SONAR_WEIGHT;
		cfg_data <= 17'(w);
		@(posedge clk);
		sb.set_register(vcf_pkg::REG_SONAR_WEIGHT, 17'(w));
		cfg_index <= vcf_pkg::REG_ACCEL_SMOOTHING;
		cfg_data <= 17'(k);
		@(posedge clk);
		sb.set_register(vcf_pkg::REG_ACCEL_SMOOTHING, 17'(k));
		cfg_we <= 1'b0;
	endtask

	// Sensor-like tick: distance walks, acceleration near one g.
	task automatic send_moving();
		int step;
		step = $urandom_range(0, 400) - 200;
		cur_dist = cur_dist + step;
		if (cur_dist < 1) cur_dist = 1;
		if (cur_dist > 32767) cur_dist = 32767;
		send_fields(vcf_pkg::OP_FUSE, cur_dist, $urandom_range(0, 6000) - 3000,
			$urandom_range(0, 6000) - 3000, 16384 + $urandom_range(0, 6000) - 3000,
			$urandom_range(20, 200));
	endtask

	task automatic send_still_run(int len);
		repeat (len) begin
			send_fields(vcf_pkg::OP_FUSE, cur_dist, $urandom_range(0, 100) - 50,
				$urandom_range(0, 100) - 50, 16384 + $urandom_range(0, 100) - 50,
				$urandom_range(50, 200));
		end
	endtask

	task automatic random_phase(int count, bit long_still);
		int sel;
		int n;
		n = 0;
		if (long_still) begin
			send_fields(vcf_pkg::OP_WARMUP, cur_dist, 0, 0, 0, 100);
			send_still_run(262);
			n = 263;
		end
		while (n < count) begin
			sel = $urandom_range(0, 99);
			if (sel < 3) begin
				cur_dist = $urandom_range(0, 32767);
				send_fields(vcf_pkg::OP_WARMUP, cur_dist, $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535));
				if (cur_dist == 0) cur_dist = 1;
				n++;
			end else if (sel < 12) begin
				send_fields(vcf_pkg::OP_FUSE, $urandom_range(0, 32767),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
				n++;
			end else if (sel < 18) begin
				send_fields(vcf_pkg::OP_FUSE, 0, $urandom_range(0, 4000) - 2000,
					$urandom_range(0, 4000) - 2000, 16384, $urandom_range(1, 300));
				n++;
			end else if (sel < 24) begin
				sel = $urandom_range(2, 8);
				send_still_run(sel);
				n += sel;
			end else begin
				send_moving();
				n++;
			end
		end
	endtask

	initial begin
		sb.clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: extremes, timeout, zero time, warm-up and a still run.
		send_fields(vcf_pkg::OP_WARMUP, 1000, 0, 0, 0, 0);
		send_fields(vcf_pkg::OP_FUSE, 1000, 0, 0, 16384, 100);
		send_fields(vcf_pkg::OP_FUSE, 32767, 32767, 32767, 32767, 1);
		send_fields(vcf_pkg::OP_FUSE, 1, -32768, -32768, -32768, 0);
		send_fields(vcf_pkg::OP_FUSE, 0, 0, 0, 0, 65535);
		send_fields(vcf_pkg::OP_FUSE, 32767, 0, 0, 0, 0);
		send_fields(vcf_pkg::OP_FUSE, 0, -32768, 32767, 0, 1);
		send_fields(vcf_pkg::OP_WARMUP, 0, 32767, -32768, 1, 65535);
		send_fields(vcf_pkg::OP_FUSE, 0, 0, 0, 16384, 10);
		send_fields(vcf_pkg::OP_FUSE, 500, 0, 0, 16384, 100);
		send_fields(vcf_pkg::OP_FUSE, 500, 0, 0, 16384, 100);
		send_fields(vcf_pkg::OP_FUSE, 500, 0, 0, 16384, 100);
		send_fields(vcf_pkg::OP_FUSE, 500, 0, 0, 16384, 100);
		send_fields(vcf_pkg::OP_FUSE, 0, 0, 0, 16384, 100);
		send_fields(vcf_pkg::OP_FUSE, 500, 0, 0, 16384, 100);
		send_fields(vcf_pkg::OP_FUSE, 900, 4000, 0, 16384, 100);
		send_fields(vcf_pkg::OP_FUSE, 32767, 0, 0, 16384, 65535);
		send_fields(vcf_pkg::OP_FUSE, 1, 0, 0, -16384, 1);
		cur_dist = 1;

		// Random requests across several weight settings.
		random_phase(250, 1'b0);
		write_config(0, 65536);
		random_phase(300, 1'b1);
		write_config(65536, 0);
		random_phase(250, 1'b0);
		write_config(131071, 131071);
		random_phase(250, 1'b0);
		write_config(1, 1);
		random_phase(250, 1'b0);
		write_config($urandom_range(0, 131071), $urandom_range(0, 131071));
		random_phase(250, 1'b0);
		write_config(32768, 6554);
		random_phase(250, 1'b0);

		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#100000000;
		$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
rtl/vcf_pkg.sv
rtl/vcf_mul.sv
rtl/vcf_div.sv
rtl/vcf_sqrt.sv
rtl/velocity_complementary_fusion_core.sv
rtl/vcf_checker.sv
sim/tb_velocity_complementary_fusion_core.sv
